// ----- hdl/fts_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the flash transfer sequencer.
package fts_pkg;

  localparam int unsigned FIFO_BYTES = 64;
  localparam int unsigned PAGE_BYTES = 256;
  localparam int unsigned PAGE_BITS  = $clog2(PAGE_BYTES);
  localparam int unsigned KIB4       = 4096;
  localparam int unsigned KIB64      = 65536;
  localparam int unsigned LEN_W      = 17;

  localparam logic [28:0] FLASH_BYTES_RST = 29'd16777216;
  localparam logic [23:0] TIMEOUT_RST     = 24'd5000;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_DONE    = 2'd1,
    CMD_ERROR   = 2'd2,
    CMD_TICK    = 2'd3
  } fts_cmd_e;

  typedef enum logic [2:0] {
    OP_READ         = 3'd0,
    OP_WRITE        = 3'd1,
    OP_ERASE        = 3'd2,
    OP_READ_ID      = 3'd3,
    OP_READ_STATUS  = 3'd4,
    OP_WRITE_STATUS = 3'd5
  } fts_op_e;

  typedef enum logic [2:0] {
    KIND_ISSUE    = 3'd0,
    KIND_DONE     = 3'd1,
    KIND_ERROR    = 3'd2,
    KIND_TIMEOUT  = 3'd3,
    KIND_REJECTED = 3'd4,
    KIND_MAPPED   = 3'd5
  } fts_kind_e;

  typedef enum logic [2:0] {
    CYC_READ         = 3'd0,
    CYC_WRITE        = 3'd1,
    CYC_ERASE4K      = 3'd2,
    CYC_ERASE64K     = 3'd3,
    CYC_READ_ID      = 3'd4,
    CYC_READ_STATUS  = 3'd5,
    CYC_WRITE_STATUS = 3'd6
  } fts_cycle_e;

  typedef enum logic [2:0] {
    CFG_FLASH_BYTES  = 3'd0,
    CFG_WINDOW_START = 3'd1,
    CFG_WINDOW_END   = 3'd2,
    CFG_WINDOW_BASE  = 3'd3,
    CFG_TIMEOUT      = 3'd4
  } fts_cfg_idx_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  op;
    logic [27:0] offset;
    logic [28:0] size;
  } fts_in_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [2:0]       cycle;
    logic [31:0]      address;
    logic [LEN_W-1:0] length;
  } fts_out_t;

  typedef struct packed {
    logic [28:0] flash_bytes;
    logic [28:0] window_start;
    logic [28:0] window_end;
    logic [31:0] window_map_base;
    logic [23:0] timeout_ticks;
  } fts_cfg_t;

  function automatic logic [2:0] cycle_of(logic [2:0] op, logic [LEN_W-1:0] len);
    logic [2:0] cyc;
    case (op)
      OP_READ:  cyc = CYC_READ;
      OP_WRITE: cyc = CYC_WRITE;
      OP_ERASE: cyc = (len == LEN_W'(KIB64)) ? CYC_ERASE64K : CYC_ERASE4K;
      default:  cyc = 3'(op + 3'd1);
    endcase
    return cyc;
  endfunction

  function automatic logic [LEN_W-1:0] chunk_len(logic [2:0] op, logic [27:0] off,
                                                 logic [28:0] rem);
    logic [LEN_W-1:0]     len;
    logic [PAGE_BITS-1:0] r;
    logic [LEN_W-1:0]     room;
    r    = off[PAGE_BITS-1:0];
    room = LEN_W'(PAGE_BYTES) - LEN_W'(r);
    if (op == OP_ERASE) begin
      len = (off[15:0] == 16'd0 && rem >= 29'(KIB64)) ? LEN_W'(KIB64) : LEN_W'(KIB4);
    end else if (op >= OP_READ_ID) begin
      len = rem[LEN_W-1:0];
    end else begin
      len = (rem < 29'(FIFO_BYTES)) ? rem[LEN_W-1:0] : LEN_W'(FIFO_BYTES);
      if (r != '0 && room < len) begin
        len = room;
      end
    end
    return len;
  endfunction

endpackage

// ----- hdl/fts_cfg.sv -----
`timescale 1ns / 1ps
// Configuration register file of the flash transfer sequencer.
module fts_cfg import fts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  output fts_cfg_t    cfg_o
);

  fts_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flash_bytes     <= FLASH_BYTES_RST;
      cfg_q.window_start    <= '0;
      cfg_q.window_end      <= '0;
      cfg_q.window_map_base <= '0;
      cfg_q.timeout_ticks   <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FLASH_BYTES:  cfg_q.flash_bytes     <= cfg_wdata_i[28:0];
        CFG_WINDOW_START: cfg_q.window_start    <= cfg_wdata_i[28:0];
        CFG_WINDOW_END:   cfg_q.window_end      <= cfg_wdata_i[28:0];
        CFG_WINDOW_BASE:  cfg_q.window_map_base <= cfg_wdata_i;
        CFG_TIMEOUT:      cfg_q.timeout_ticks   <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/flash_transfer_sequencer_unit.sv -----
`timescale 1ns / 1ps
// Top level of the flash transfer sequencer: input register, event logic, result register.
// The unit takes one event (new request, transfer done, transfer error or microsecond tick)
// per clock and answers with at most one result: an issued transfer, done, error abort,
// timeout abort, rejected or mapped read. Throughput is one event per cycle while the
// output is not stalled; an event's result passes through the input register, the
// combinational event logic and the result register. An event without a result still
// waits for a free result register. The input side keeps taking events while a result
// waits on the output, until both registers are full.
module flash_transfer_sequencer_unit import fts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  fts_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output fts_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  fts_cfg_t cfg;

  fts_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  logic     in_valid_q;
  fts_in_t  in_q;
  logic     out_valid_q;
  fts_out_t out_q;
  logic     proc_fire;

  logic             busy_q, busy_d;
  logic [2:0]       op_q, op_d;
  logic [27:0]      off_q, off_d;
  logic [28:0]      rem_q, rem_d;
  logic [LEN_W-1:0] chunk_q, chunk_d;
  logic [23:0]      wait_q, wait_d;

  logic             res_valid;
  fts_out_t         res;
  logic             do_issue;
  logic [LEN_W-1:0] iss_len;
  logic [29:0]      req_end;
  logic [28:0]      chunk_ext;

  assign proc_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc_fire;
  assign req_end    = {2'b00, in_q.offset} + {1'b0, in_q.size};
  assign chunk_ext  = {12'd0, chunk_q};

  always_comb begin
    busy_d    = busy_q;
    op_d      = op_q;
    off_d     = off_q;
    rem_d     = rem_q;
    chunk_d   = chunk_q;
    wait_d    = wait_q;
    res_valid = 1'b0;
    res       = '0;
    do_issue  = 1'b0;
    iss_len   = '0;
    case (in_q.cmd)
      CMD_REQUEST: begin
        res_valid = 1'b1;
        res.kind  = KIND_REJECTED;
        if (busy_q || in_q.op > OP_WRITE_STATUS) begin
          res.kind = KIND_REJECTED;
        end else if (in_q.op <= OP_ERASE) begin
          if (req_end > {1'b0, cfg.flash_bytes}) begin
            res.kind = KIND_REJECTED;
          end else if (in_q.op == OP_ERASE &&
                       (in_q.offset[11:0] != 12'd0 || in_q.size[11:0] != 12'd0)) begin
            res.kind = KIND_REJECTED;
          end else if (in_q.op == OP_READ && {1'b0, in_q.offset} >= cfg.window_start &&
                       req_end < {1'b0, cfg.window_end}) begin
            res.kind    = KIND_MAPPED;
            res.address = cfg.window_map_base - {3'd0, cfg.window_start}
                          + {4'd0, in_q.offset};
          end else if (in_q.size == '0) begin
            res.kind    = KIND_DONE;
            res.cycle   = cycle_of(in_q.op, '0);
            res.address = {4'd0, in_q.offset};
          end else begin
            op_d     = in_q.op;
            off_d    = in_q.offset;
            rem_d    = in_q.size;
            do_issue = 1'b1;
          end
        end else begin
          op_d     = in_q.op;
          off_d    = '0;
          rem_d    = (in_q.op == OP_READ_ID) ? 29'd3 : 29'd1;
          do_issue = 1'b1;
        end
      end
      CMD_DONE: begin
        if (busy_q) begin
          off_d = off_q + 28'(chunk_q);
          rem_d = (rem_q > chunk_ext) ? rem_q - chunk_ext : '0;
          if (rem_d == '0) begin
            busy_d      = 1'b0;
            res_valid   = 1'b1;
            res.kind    = KIND_DONE;
            res.cycle   = cycle_of(op_q, chunk_q);
            res.address = {4'd0, off_q};
            res.length  = chunk_q;
          end else begin
            do_issue = 1'b1;
          end
        end
      end
      CMD_ERROR: begin
        if (busy_q) begin
          busy_d      = 1'b0;
          rem_d       = '0;
          res_valid   = 1'b1;
          res.kind    = KIND_ERROR;
          res.cycle   = cycle_of(op_q, chunk_q);
          res.address = {4'd0, off_q};
          res.length  = chunk_q;
        end
      end
      default: begin
        if (busy_q) begin
          wait_d = wait_q + 24'd1;
          if (wait_d >= cfg.timeout_ticks) begin
            busy_d      = 1'b0;
            rem_d       = '0;
            res_valid   = 1'b1;
            res.kind    = KIND_TIMEOUT;
            res.cycle   = cycle_of(op_q, chunk_q);
            res.address = {4'd0, off_q};
            res.length  = chunk_q;
          end
        end
      end
    endcase
    if (do_issue) begin
      iss_len     = chunk_len(op_d, off_d, rem_d);
      chunk_d     = iss_len;
      wait_d      = '0;
      busy_d      = 1'b1;
      res_valid   = 1'b1;
      res.kind    = KIND_ISSUE;
      res.cycle   = cycle_of(op_d, iss_len);
      res.address = {4'd0, off_d};
      res.length  = iss_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      op_q        <= '0;
      off_q       <= '0;
      rem_q       <= '0;
      chunk_q     <= '0;
      wait_q      <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (proc_fire) begin
        in_valid_q <= 1'b0;
      end
      if (proc_fire) begin
        out_valid_q <= res_valid;
        busy_q      <= busy_d;
        op_q        <= op_d;
        off_q       <= off_d;
        rem_q       <= rem_d;
        chunk_q     <= chunk_d;
        wait_q      <= wait_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (proc_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_issue_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && res_valid && res.kind == KIND_ISSUE |=> busy_q && wait_q == '0)
    else $error("issued transfer did not arm the wait counter");

  a_issue_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && res_valid && res.kind == KIND_ISSUE |-> res.length != '0)
    else $error("issued transfer with zero length");

  a_abort_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && res_valid && (res.kind == KIND_TIMEOUT || res.kind == KIND_ERROR)
    |=> !busy_q)
    else $error("abort left the sequencer busy");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> rem_q == '0)
    else $error("bytes left while idle");

endmodule
